/* design/pita_pkg.sv */
// Shared types, codes and character constants for the padded integer to ASCII formatter.
// Used by every module of the block; depends on nothing else.
package pita_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int DIGIT_SLOTS = 32;
   localparam int DIGIT_IDX_W = $clog2(DIGIT_SLOTS);
   localparam int DIGIT_CNT_W = $clog2(DIGIT_SLOTS + 1);
   localparam int FIELD_W     = 7;

   localparam logic [2:0] CMD_DEC   = 3'd0;
   localparam logic [2:0] CMD_HEX_L = 3'd1;
   localparam logic [2:0] CMD_HEX_U = 3'd2;
   localparam logic [2:0] CMD_BIN   = 3'd3;
   localparam logic [2:0] CMD_PTR   = 3'd4;
   localparam logic [2:0] CMD_CHAR  = 3'd5;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_UPPER = 8'h41;
   localparam logic [7:0] CH_LOWER = 8'h61;

   localparam logic [7:0]  COLOR_RESET = 8'd7;
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] value;
      logic [6:0]  min_width;
      logic        zero_fill;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic [7:0] attribute;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        mag;
      logic               neg;
      logic               zero_fill;
      logic [FIELD_W-1:0] field_w;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + {4'd0, d};
      end else begin
         c = (upper ? CH_UPPER : CH_LOWER) + {4'd0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

/* design/padded_integer_to_ascii.sv */
// Padded integer to ASCII formatter: an operand goes in, a string of characters comes out.
// Per request the back end takes it from the queue, converts it digit by digit into a store
// (a character is stored as it is, binary gives at most 32 digits), sets up the padding,
// then steps through sign and padding and emits a field of up to 64 characters. It handles
// one request at a time and waits while results stall.
// Reset is synchronous: it empties the queue, drops any result and sets the colour to 7.
module padded_integer_to_ascii
   import pita_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic [7:0]      color_ff, color_in;
   fifo_status_type fifo_status;
   logic            push;
   logic            pop;
   desc_type        push_desc;
   desc_type        head;

   always_comb begin
      color_in = csr_wr_en ? csr_wr_data : color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= COLOR_RESET;
      end else begin
         color_ff <= color_in;
      end
   end

   pita_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .fifo_status (fifo_status),
      .push        (push),
      .push_desc   (push_desc)
   );

   pita_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .status    (fifo_status)
   );

   pita_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .head        (head),
      .pop         (pop),
      .color       (color_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!fifo_status.full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("queue read while empty");

endmodule

/* design/pita_front.sv */
// Front end: accepts requests, drops unused kinds and classifies the rest into descriptors.
// Depends on pita_pkg; feeds pita_fifo.
module pita_front
   import pita_pkg::*;
(
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   input  fifo_status_type fifo_status,
   output logic            push,
   output desc_type        push_desc
);

   logic [FIELD_W-1:0] width_sat;
   logic               is_neg;

   always_comb begin
      req_ready = !fifo_status.full;
      push      = req_valid && req_ready && (req_data.cmd <= CMD_CHAR);

      width_sat = (req_data.min_width > FIELD_W'(MAX_WIDTH)) ? FIELD_W'(MAX_WIDTH)
                                                              : req_data.min_width;
      is_neg = (req_data.cmd == CMD_DEC) && req_data.value[31];

      push_desc.kind      = req_data.cmd;
      push_desc.neg       = is_neg;
      push_desc.mag       = is_neg ? (32'd0 - req_data.value) : req_data.value;
      push_desc.zero_fill = req_data.zero_fill && (req_data.cmd != CMD_CHAR);
      if (req_data.cmd == CMD_PTR) begin
         push_desc.field_w = (width_sat > FIELD_W'(2)) ? width_sat - FIELD_W'(2) : '0;
      end else begin
         push_desc.field_w = width_sat;
      end
   end

endmodule

/* design/pita_fifo.sv */
// Two-entry descriptor queue between the front end and the back end.
// Depends on pita_pkg for the descriptor and status types.
module pita_fifo
   import pita_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  desc_type        push_desc,
   input  logic            pop,
   output desc_type        head,
   output fifo_status_type status
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in    = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + {1'b0, push} - {1'b0, pop};
      head         = entry_ff[rd_ptr_ff];
      status.full  = (count_ff == 2'd2);
      status.empty = (count_ff == 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

/* design/pita_back.sv */
// Back end: converts one descriptor into digits in a small store, then emits the field.
// Depends on pita_pkg; takes descriptors from pita_fifo and drives the result register.
module pita_back
   import pita_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  fifo_status_type fifo_status,
   input  desc_type        head,
   output logic            pop,
   input  logic [7:0]      color,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CONV, ST_SETUP, ST_PFX0, ST_PFX1, ST_SIGN1, ST_PAD, ST_SIGN2, ST_DIGITS
   } state_type;

   state_type              state_ff, state_in;
   desc_type               desc_ff, desc_in;
   logic [31:0]            remaining_value_ff, remaining_value_in;
   logic [DIGIT_CNT_W-1:0] nd_ff, nd_in;
   logic [DIGIT_IDX_W-1:0] dig_idx_ff, dig_idx_in;
   logic [FIELD_W-1:0]     pad_ff, pad_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [7:0]             digit_store [DIGIT_SLOTS];
   logic [7:0]             rd_ff;
   logic                   mem_we;
   logic [DIGIT_IDX_W-1:0] mem_addr;
   logic [7:0]             mem_wdata;

   logic                   out_free;
   logic [63:0]            prod;
   logic [31:0]            quot;
   logic [31:0]            rem_wide;
   logic [3:0]             digit;
   logic [FIELD_W-1:0]     len;
   logic [7:0]             fill_char;

   always_comb begin
      prod     = {32'd0, remaining_value_ff} * {32'd0, RECIP_TEN};
      rem_wide = '0;
      unique case (desc_ff.kind)
         CMD_DEC: begin
            quot     = {3'd0, prod[63:RECIP_SHIFT]};
            rem_wide = remaining_value_ff - {quot[28:0], 3'd0} - {quot[30:0], 1'b0};
            digit    = rem_wide[3:0];
         end
         CMD_BIN: begin
            quot  = {1'b0, remaining_value_ff[31:1]};
            digit = {3'd0, remaining_value_ff[0]};
         end
         default: begin
            quot  = {4'd0, remaining_value_ff[31:4]};
            digit = remaining_value_ff[3:0];
         end
      endcase
      len       = {1'b0, nd_ff} + {{(FIELD_W-1){1'b0}}, desc_ff.neg};
      fill_char = desc_ff.zero_fill ? CH_ZERO : CH_SPACE;
   end

   always_comb begin
      state_in           = state_ff;
      desc_in            = desc_ff;
      remaining_value_in = remaining_value_ff;
      nd_in              = nd_ff;
      dig_idx_in         = dig_idx_ff;
      pad_in             = pad_ff;
      out_free           = !rsp_valid_ff || rsp_ready;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_data_in        = rsp_data_ff;
      pop                = 1'b0;
      mem_we             = 1'b0;
      mem_addr           = nd_ff[DIGIT_IDX_W-1:0];
      mem_wdata          = digit_char(digit, desc_ff.kind == CMD_HEX_U);

      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_status.empty) begin
               pop                = 1'b1;
               desc_in            = head;
               remaining_value_in = head.mag;
               nd_in              = '0;
               state_in           = ST_CONV;
            end
         end
         ST_CONV: begin
            mem_we = 1'b1;
            if (desc_ff.kind == CMD_CHAR) begin
               mem_addr           = '0;
               mem_wdata          = remaining_value_ff[7:0];
               nd_in              = DIGIT_CNT_W'(1);
               dig_idx_in         = '0;
               remaining_value_in = '0;
               state_in           = ST_SETUP;
            end else begin
               nd_in              = nd_ff + DIGIT_CNT_W'(1);
               remaining_value_in = quot;
               if (quot == 32'd0 || nd_ff == DIGIT_CNT_W'(DIGIT_SLOTS - 1)) begin
                  dig_idx_in         = nd_ff[DIGIT_IDX_W-1:0];
                  remaining_value_in = '0;
                  state_in           = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            pad_in   = (desc_ff.field_w > len) ? desc_ff.field_w - len : '0;
            state_in = (desc_ff.kind == CMD_PTR) ? ST_PFX0 : ST_SIGN1;
         end
         ST_PFX0: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_char: CH_ZERO, attribute: color, last: 1'b0};
               state_in     = ST_PFX1;
            end
         end
         ST_PFX1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_char: CH_X, attribute: color, last: 1'b0};
               state_in     = ST_SIGN1;
            end
         end
         ST_SIGN1: begin
            if (desc_ff.neg && desc_ff.zero_fill) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{out_char: CH_MINUS, attribute: color, last: 1'b0};
                  state_in     = ST_PAD;
               end
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (pad_ff == '0) begin
               state_in = ST_SIGN2;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_char: fill_char, attribute: color, last: 1'b0};
               pad_in       = pad_ff - FIELD_W'(1);
            end
         end
         ST_SIGN2: begin
            if (desc_ff.neg && !desc_ff.zero_fill) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{out_char: CH_MINUS, attribute: color, last: 1'b0};
                  state_in     = ST_DIGITS;
               end
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_char: rd_ff, attribute: color,
                                last: (dig_idx_ff == '0)};
               if (dig_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  dig_idx_in = dig_idx_ff - DIGIT_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         remaining_value_ff <= '0;
         nd_ff              <= '0;
         dig_idx_ff         <= '0;
         pad_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         remaining_value_ff <= remaining_value_in;
         nd_ff              <= nd_in;
         dig_idx_ff         <= dig_idx_in;
         pad_ff             <= pad_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      desc_ff     <= desc_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_store[mem_addr] <= mem_wdata;
      end
      rd_ff <= digit_store[dig_idx_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
